// ----- rtl/pold_pkg.sv -----
`default_nettype none
package pold_pkg;

    localparam int unsigned CW       = 32;
    localparam int unsigned RAD_W    = 128;
    localparam int unsigned SQ_N     = 64;
    localparam int unsigned SQ_REM_W = SQ_N + 2;
    localparam int unsigned DV_N     = 42;
    localparam int unsigned DEN_W    = 63;
    localparam int unsigned REM_W    = DEN_W + 1;

    localparam int unsigned ST_SQ0 = 5;
    localparam int unsigned ST_NUM = ST_SQ0 + SQ_N + 1;
    localparam int unsigned ST_MAG = ST_NUM + 1;
    localparam int unsigned ST_DV0 = ST_MAG + 1;
    localparam int unsigned ST_X   = ST_DV0 + DV_N + 1;
    localparam int unsigned ST_P   = ST_X + 1;
    localparam int unsigned ST_Y   = ST_P + 1;

    localparam logic [DV_N-1:0] Q_MAX = DV_N'(64'h100_0000_0000);

    typedef enum logic [1:0] {
        CFG_SLOPE,
        CFG_ICPT,
        CFG_HORZ,
        CFG_VERT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CW-1:0] bxlo;
        logic signed [CW-1:0] bxhi;
        logic signed [CW-1:0] bylo;
        logic signed [CW-1:0] byhi;
        logic signed [CW-1:0] x0;
        logic                 hv_found;
        logic        [CW-1:0] hv_x;
        logic        [CW-1:0] hv_y;
        logic                 gen;
    } t_ctx;

    typedef struct packed {
        logic signed [RAD_W-1:0] tt;
        logic        [DEN_W-1:0] a;
        logic                    disc;
    } t_sqa;

    typedef struct packed {
        logic disc;
        logic neg_p;
        logic neg_m;
        logic pre_p;
        logic pre_m;
    } t_dva;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/pold_mul.sv -----
`default_nettype none
module pold_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_prod
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= i_a[31:0]  * i_b[31:0];
            r_p01  <= i_a[31:0]  * i_b[63:32];
            r_p10  <= i_a[63:32] * i_b[31:0];
            r_p11  <= i_a[63:32] * i_b[63:32];
            r_prod <= {64'b0, r_p00} + {32'b0, r_p01, 32'b0}
                    + {32'b0, r_p10, 32'b0} + {r_p11, 64'b0};
        end
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ----- rtl/pold_sqrt_cell.sv -----
`default_nettype none
module pold_sqrt_cell import pold_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [RAD_W-1:0]    i_rad,
    input  logic [SQ_REM_W-1:0] i_rem,
    input  logic [SQ_N-1:0]     i_root,
    output logic [RAD_W-1:0]    o_rad,
    output logic [SQ_REM_W-1:0] o_rem,
    output logic [SQ_N-1:0]     o_root
);
    logic [SQ_REM_W-1:0] rem2, trial;
    logic                ge;
    logic [RAD_W-1:0]    r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SQ_N-1:0]     r_root;

    always_comb begin
        rem2  = {i_rem[SQ_N-1:0], i_rad[RAD_W-1 -: 2]};
        trial = {i_root, 2'b01};
        ge    = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? rem2 - trial : rem2;
            r_root <= {i_root[SQ_N-2:0], ge};
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ----- rtl/pold_div_cell.sv -----
`default_nettype none
module pold_div_cell import pold_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DV_N-1:0]  i_num,
    input  logic [REM_W-1:0] i_rem,
    input  logic [DV_N-1:0]  i_q,
    input  logic [DEN_W-1:0] i_den,
    output logic [DV_N-1:0]  o_num,
    output logic [REM_W-1:0] o_rem,
    output logic [DV_N-1:0]  o_q,
    output logic [DEN_W-1:0] o_den
);
    logic [REM_W-1:0] rem2, den;
    logic             ge;
    logic [DV_N-1:0]  r_num, r_q;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    always_comb begin
        rem2 = {i_rem[REM_W-2:0], i_num[DV_N-1]};
        den  = {1'b0, i_den};
        ge   = rem2 >= den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= {i_num[DV_N-2:0], 1'b0};
            r_rem <= ge ? rem2 - den : rem2;
            r_q   <= {i_q[DV_N-2:0], ge};
            r_den <= i_den;
        end
    end

    assign o_num = r_num;
    assign o_rem = r_rem;
    assign o_q   = r_q;
    assign o_den = r_den;
endmodule
`default_nettype wire

// ----- rtl/point_on_line_at_distance_in_box_core.sv -----
`default_nettype none
// Finds the first point on the configured line at distance span from the origin that lies
// inside the box spanned by origin and corner. One request is taken every clock cycle while
// o_ready is high; the pipeline is built around the 64-cell square-root chain and the
// two 42-cell divider chains that follow it. A two-entry output queue lets requests keep
// flowing while one result waits; the whole pipeline halts only when both entries are full.
module point_on_line_at_distance_in_box_core import pold_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_origin_x,
    input  logic signed [CW-1:0] i_origin_y,
    input  logic signed [CW-1:0] i_corner_x,
    input  logic signed [CW-1:0] i_corner_y,
    input  logic [CW-2:0]        i_span,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic signed [CW-1:0] o_point_x,
    output logic signed [CW-1:0] o_point_y,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_data
);
    function automatic logic in_rng(logic signed [CW+1:0] v, logic signed [CW-1:0] lo,
                                    logic signed [CW-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    logic signed [CW-1:0] r_slope, r_icpt;
    logic                 r_horz, r_vert;
    logic                 en, push, pop;
    logic [1:0]           r_cnt, wpos;
    logic [ST_Y:1]        r_v;
    t_ctx                 r_ctx [1:ST_Y];
    t_ctx                 n_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope <= '0;
            r_icpt  <= '0;
            r_horz  <= 1'b1;
            r_vert  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLOPE: r_slope <= i_cfg_data;
                CFG_ICPT:  r_icpt  <= i_cfg_data;
                CFG_HORZ:  r_horz  <= i_cfg_data[0];
                CFG_VERT:  r_vert  <= i_cfg_data[0];
                default:   r_vert  <= r_vert;
            endcase
        end
    end

    logic signed [CW+1:0] x0e, y0e, de;
    always_comb begin
        x0e = i_origin_x;
        y0e = i_origin_y;
        de  = {3'b000, i_span};
        n_ctx.bxlo = (i_origin_x < i_corner_x) ? i_origin_x : i_corner_x;
        n_ctx.bxhi = (i_origin_x < i_corner_x) ? i_corner_x : i_origin_x;
        n_ctx.bylo = (i_origin_y < i_corner_y) ? i_origin_y : i_corner_y;
        n_ctx.byhi = (i_origin_y < i_corner_y) ? i_corner_y : i_origin_y;
        n_ctx.x0   = i_origin_x;
        n_ctx.gen  = !r_horz && !r_vert;
        n_ctx.hv_found = 1'b0;
        n_ctx.hv_x     = '0;
        n_ctx.hv_y     = '0;
        if (r_horz) begin
            if (in_rng(x0e - de, n_ctx.bxlo, n_ctx.bxhi)) begin
                n_ctx.hv_found = 1'b1;
                n_ctx.hv_x     = CW'(x0e - de);
                n_ctx.hv_y     = i_origin_y;
            end else if (in_rng(x0e + de, n_ctx.bxlo, n_ctx.bxhi)) begin
                n_ctx.hv_found = 1'b1;
                n_ctx.hv_x     = CW'(x0e + de);
                n_ctx.hv_y     = i_origin_y;
            end
        end else if (r_vert) begin
            if (in_rng(y0e - de, n_ctx.bylo, n_ctx.byhi)) begin
                n_ctx.hv_found = 1'b1;
                n_ctx.hv_x     = i_origin_x;
                n_ctx.hv_y     = CW'(y0e - de);
            end else if (in_rng(y0e + de, n_ctx.bylo, n_ctx.byhi)) begin
                n_ctx.hv_found = 1'b1;
                n_ctx.hv_x     = i_origin_x;
                n_ctx.hv_y     = CW'(y0e + de);
            end
        end
    end

    assign en      = (r_cnt != 2'd2);
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[ST_Y-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[1] <= n_ctx;
            for (int k = 2; k <= ST_Y; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
        end
    end

    // line offset terms
    logic signed [63:0]   r1_kx, r1_kk;
    logic [61:0]          r1_dd;
    logic signed [CW:0]   r1_cmy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kx  <= r_slope * i_origin_x;
            r1_kk  <= r_slope * r_slope;
            r1_dd  <= i_span * i_span;
            r1_cmy <= r_icpt - i_origin_y;
        end
    end

    logic signed [CW+16:0] cmy_s;
    logic signed [63:0]    e, e_neg;
    logic [DEN_W-1:0]      r2_a, r2_ea, r3_a, r4_a;
    logic [CW-1:0]         r2_ka;
    logic [61:0]           r2_dd;
    logic                  r2_tneg, r3_tneg, r4_tneg;
    always_comb begin
        cmy_s = {r1_cmy, 16'h0000};
        e     = r1_kx + cmy_s;
        e_neg = -e;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a    <= r1_kk[DEN_W-1:0] + DEN_W'(64'h1_0000_0000);
            r2_ea   <= e[63] ? e_neg[DEN_W-1:0] : e[DEN_W-1:0];
            r2_ka   <= r_slope[CW-1] ? CW'(-r_slope) : r_slope;
            r2_dd   <= r1_dd;
            r2_tneg <= (r_slope > 0 && e > 0) || (r_slope < 0 && e < 0);
            r3_a    <= r2_a;
            r3_tneg <= r2_tneg;
            r4_a    <= r3_a;
            r4_tneg <= r3_tneg;
        end
    end

    logic [RAD_W-1:0] m_p, m_qq, m_t;
    pold_mul u_mul_p (
        .i_clk(i_clk), .i_en(en), .i_a({1'b0, r2_a}), .i_b({2'b00, r2_dd}), .o_prod(m_p)
    );
    pold_mul u_mul_qq (
        .i_clk(i_clk), .i_en(en), .i_a({1'b0, r2_ea}), .i_b({1'b0, r2_ea}), .o_prod(m_qq)
    );
    pold_mul u_mul_t (
        .i_clk(i_clk), .i_en(en), .i_a({32'b0, r2_ka}), .i_b({1'b0, r2_ea}), .o_prod(m_t)
    );

    // discriminant and square root chain
    t_sqa             r_sqa [ST_SQ0:ST_NUM-1];
    logic [RAD_W-1:0] r5_rad;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqa[ST_SQ0].disc <= m_p >= m_qq;
            r_sqa[ST_SQ0].a    <= r4_a;
            r_sqa[ST_SQ0].tt   <= r4_tneg ? -m_t : m_t;
            r5_rad             <= m_p - m_qq;
            for (int k = ST_SQ0 + 1; k < ST_NUM; k++) begin
                r_sqa[k] <= r_sqa[k-1];
            end
        end
    end

    logic [RAD_W-1:0]    w_rad  [0:SQ_N];
    logic [SQ_REM_W-1:0] w_rem  [0:SQ_N];
    logic [SQ_N-1:0]     w_root [0:SQ_N];
    assign w_rad[0]  = r5_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        pold_sqrt_cell u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_rad(w_rad[j]), .i_rem(w_rem[j]), .i_root(w_root[j]),
            .o_rad(w_rad[j+1]), .o_rem(w_rem[j+1]), .o_root(w_root[j+1])
        );
    end

    // candidate numerators and magnitudes
    logic [RAD_W-1:0]  s16;
    logic signed [RAD_W-1:0] r70_nump, r70_numm;
    logic [DEN_W-1:0]  r70_a, r71_a;
    logic              r70_disc, r71_disc, r71_negp, r71_negm;
    logic [RAD_W-1:0]  r71_magp, r71_magm;
    assign s16 = {48'b0, w_root[SQ_N], 16'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r70_nump <= r_sqa[ST_NUM-1].tt + s16;
            r70_numm <= r_sqa[ST_NUM-1].tt - s16;
            r70_a    <= r_sqa[ST_NUM-1].a;
            r70_disc <= r_sqa[ST_NUM-1].disc;
            r71_negp <= r70_nump[RAD_W-1];
            r71_negm <= r70_numm[RAD_W-1];
            r71_magp <= r70_nump[RAD_W-1] ? -r70_nump : r70_nump;
            r71_magm <= r70_numm[RAD_W-1] ? -r70_numm : r70_numm;
            r71_a    <= r70_a;
            r71_disc <= r70_disc;
        end
    end

    // divider chains
    t_dva             r_dva [ST_DV0:ST_X-1];
    logic [DV_N-1:0]  r72_nump, r72_numm;
    logic [REM_W-1:0] r72_remp, r72_remm;
    logic [DEN_W-1:0] r72_a;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dva[ST_DV0].disc  <= r71_disc;
            r_dva[ST_DV0].neg_p <= r71_negp;
            r_dva[ST_DV0].neg_m <= r71_negm;
            r_dva[ST_DV0].pre_p <= r71_magp[RAD_W-1:DV_N] < {23'b0, r71_a};
            r_dva[ST_DV0].pre_m <= r71_magm[RAD_W-1:DV_N] < {23'b0, r71_a};
            r72_nump <= r71_magp[DV_N-1:0];
            r72_numm <= r71_magm[DV_N-1:0];
            r72_remp <= {1'b0, r71_magp[DV_N+DEN_W-1:DV_N]};
            r72_remm <= {1'b0, r71_magm[DV_N+DEN_W-1:DV_N]};
            r72_a    <= r71_a;
            for (int k = ST_DV0 + 1; k < ST_X; k++) begin
                r_dva[k] <= r_dva[k-1];
            end
        end
    end

    logic [DV_N-1:0]  wp_num [0:DV_N], wm_num [0:DV_N];
    logic [REM_W-1:0] wp_rem [0:DV_N], wm_rem [0:DV_N];
    logic [DV_N-1:0]  wp_q   [0:DV_N], wm_q   [0:DV_N];
    logic [DEN_W-1:0] wp_den [0:DV_N], wm_den [0:DV_N];
    assign wp_num[0] = r72_nump;
    assign wp_rem[0] = r72_remp;
    assign wp_q[0]   = '0;
    assign wp_den[0] = r72_a;
    assign wm_num[0] = r72_numm;
    assign wm_rem[0] = r72_remm;
    assign wm_q[0]   = '0;
    assign wm_den[0] = r72_a;

    for (genvar j = 0; j < DV_N; j++) begin : g_div
        pold_div_cell u_cell_p (
            .i_clk(i_clk), .i_en(en),
            .i_num(wp_num[j]), .i_rem(wp_rem[j]), .i_q(wp_q[j]), .i_den(wp_den[j]),
            .o_num(wp_num[j+1]), .o_rem(wp_rem[j+1]), .o_q(wp_q[j+1]), .o_den(wp_den[j+1])
        );
        pold_div_cell u_cell_m (
            .i_clk(i_clk), .i_en(en),
            .i_num(wm_num[j]), .i_rem(wm_rem[j]), .i_q(wm_q[j]), .i_den(wm_den[j]),
            .o_num(wm_num[j+1]), .o_rem(wm_rem[j+1]), .o_q(wm_q[j+1]), .o_den(wm_den[j+1])
        );
    end

    // candidate x
    t_ctx                 cx;
    t_dva                 dv;
    logic signed [DV_N:0]   up, um;
    logic signed [DV_N+1:0] xp, xm;
    logic                 r115_okp, r115_okm, r116_okp, r116_okm;
    logic signed [CW-1:0] r115_xp, r115_xm, r116_xp, r116_xm;
    logic signed [63:0]   r116_prp, r116_prm;
    always_comb begin
        cx = r_ctx[ST_X-1];
        dv = r_dva[ST_X-1];
        up = dv.neg_p ? -$signed({1'b0, wp_q[DV_N]}) : $signed({1'b0, wp_q[DV_N]});
        um = dv.neg_m ? -$signed({1'b0, wm_q[DV_N]}) : $signed({1'b0, wm_q[DV_N]});
        xp = cx.x0 + up;
        xm = cx.x0 + um;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r115_okp <= dv.disc && dv.pre_p && (wp_q[DV_N] <= Q_MAX)
                        && (xp >= cx.bxlo) && (xp <= cx.bxhi);
            r115_okm <= dv.disc && dv.pre_m && (wm_q[DV_N] <= Q_MAX)
                        && (xm >= cx.bxlo) && (xm <= cx.bxhi);
            r115_xp  <= xp[CW-1:0];
            r115_xm  <= xm[CW-1:0];
            r116_prp <= r_slope * r115_xp;
            r116_prm <= r_slope * r115_xm;
            r116_okp <= r115_okp;
            r116_okm <= r115_okm;
            r116_xp  <= r115_xp;
            r116_xm  <= r115_xm;
        end
    end

    // candidate y and final pick
    t_ctx                 cy;
    logic signed [63:0]   adjp, adjm;
    logic signed [47:0]   yqp, yqm;
    logic signed [48:0]   yp, ym;
    t_res                 n_res, r117_res;
    always_comb begin
        cy   = r_ctx[ST_P];
        adjp = r116_prp[63] ? r116_prp + 64'sd65535 : r116_prp;
        adjm = r116_prm[63] ? r116_prm + 64'sd65535 : r116_prm;
        yqp  = adjp[63:16];
        yqm  = adjm[63:16];
        yp   = yqp + r_icpt;
        ym   = yqm + r_icpt;
        n_res = '0;
        if (!cy.gen) begin
            n_res.found = cy.hv_found;
            n_res.x     = cy.hv_x;
            n_res.y     = cy.hv_y;
        end else if (r116_okp && yp >= cy.bylo && yp <= cy.byhi) begin
            n_res.found = 1'b1;
            n_res.x     = r116_xp;
            n_res.y     = yp[CW-1:0];
        end else if (r116_okm && ym >= cy.bylo && ym <= cy.byhi) begin
            n_res.found = 1'b1;
            n_res.x     = r116_xm;
            n_res.y     = ym[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r117_res <= n_res;
        end
    end

    // output queue
    t_res       r_q [2];
    assign push = en && r_v[ST_Y];
    assign pop  = o_valid && i_ready;
    assign wpos = r_cnt - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && wpos == 2'd0) begin
            r_q[0] <= r117_res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push && wpos == 2'd1) begin
            r_q[1] <= r117_res;
        end
    end

    assign o_valid   = (r_cnt != 2'd0);
    assign o_found   = r_q[0].found;
    assign o_point_x = r_q[0].x;
    assign o_point_y = r_q[0].y;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output queue overflow");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[1]) else $error("accepted request lost");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_v)) else $error("pipeline moved while stalled");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_point_x == 0 && o_point_y == 0)
        else $error("miss result not zero");
`endif
endmodule
`default_nettype wire
